/* sv/cnms_pkg.sv */
package cnms_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int MAG_W  = 12;
  localparam int GRAD_W = 9;
  localparam int PROD_W = GRAD_W + 2 + MAG_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pix_tag_t;

endpackage

/* sv/canny_nonmax_suppression_unit.sv */
// A result passes stage 1, stage 2, stage 3 and the output register after acceptance of
// the item that completes its 3x3 window (the pixel one row down and one column right);
// back-pressure from out_ready can hold it there. Throughput: 1 item per cycle unless
// stalled; each item makes one read and one write per line store.
// Reset (rst, synchronous): clears row/column counters, window, center gradient,
// pipeline valids and sets the frame size to 1024x1024. Line stores are not cleared.
module canny_nonmax_suppression_unit import cnms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  reg_index_t               cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MAG_W-1:0]         magnitude,
  input  logic signed [GRAD_W-1:0] grad_x,
  input  logic signed [GRAD_W-1:0] grad_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAG_W-1:0]         edge_value,
  output logic                     kept,
  output logic [POS_W-1:0]         pixel_row,
  output logic [POS_W-1:0]         pixel_col,
  output logic                     last_of_frame
);

  function automatic logic [SUM_W-1:0] abs_of(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  // configuration
  logic [SIZE_W-1:0] image_width, image_height;
  logic [SIZE_W-1:0] width_eff, height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(MAX_WIDTH);
      image_height <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff  = (image_width < SIZE_W'(3)) ? SIZE_W'(3) :
                 (image_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : image_width;
    height_eff = (image_height < SIZE_W'(3)) ? SIZE_W'(3) :
                 (image_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : image_height;
  end

  // flow control
  logic v1, v2, v3;
  logic out_free, s3_free, s2_free, s1_free, accept, adv12;

  assign out_free = !out_valid || out_ready;
  assign s3_free  = !v3 || out_free;
  assign s2_free  = !v2 || s3_free;
  assign s1_free  = !v1 || s2_free;
  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;
  assign adv12    = v1 && s2_free;

  // raster position
  logic [COL_W-1:0] col_count, col_cur;
  logic [ROW_W-1:0] row_count, row_cur;
  logic             col_wrap, row_wrap;
  pix_tag_t         tag_in;

  always_comb begin
    col_cur  = (SIZE_W'(col_count) >= width_eff) ? COL_W'(width_eff - SIZE_W'(1)) : col_count;
    row_cur  = (SIZE_W'(row_count) >= height_eff) ? ROW_W'(height_eff - SIZE_W'(1)) : row_count;
    col_wrap = (SIZE_W'(col_cur) + SIZE_W'(1)) >= width_eff;
    row_wrap = (SIZE_W'(row_cur) + SIZE_W'(1)) >= height_eff;
    tag_in.emit = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    tag_in.last = (SIZE_W'(row_cur) == height_eff - SIZE_W'(1)) &&
                  (SIZE_W'(col_cur) == width_eff - SIZE_W'(1));
    tag_in.row  = POS_W'(row_cur - ROW_W'(1));
    tag_in.col  = POS_W'(col_cur - COL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_count <= col_cur + COL_W'(1);
        row_count <= row_cur;
      end
    end
  end

  // stage 1: input register and line store read
  logic [MAG_W-1:0]    mag1;
  logic [2*GRAD_W-1:0] gxy1;
  logic [COL_W-1:0]    col1;
  pix_tag_t            tag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_free) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag1 <= magnitude;
      gxy1 <= {grad_y, grad_x};
      col1 <= col_cur;
      tag1 <= tag_in;
    end
  end

  logic [MAG_W-1:0]    mag_line_older [MAX_WIDTH];
  logic [MAG_W-1:0]    mag_line_newer [MAX_WIDTH];
  logic [2*GRAD_W-1:0] grad_line      [MAX_WIDTH];
  logic [MAG_W-1:0]    top_q, mid_q;
  logic [2*GRAD_W-1:0] grad_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      top_q  <= mag_line_older[col_cur];
      mid_q  <= mag_line_newer[col_cur];
      grad_q <= grad_line[col_cur];
    end
    // write back the column of the item leaving stage 1
    if (adv12) begin
      mag_line_older[col1] <= mid_q;
      mag_line_newer[col1] <= mag1;
      grad_line[col1]      <= gxy1;
    end
  end

  // stage 2: window shift and center gradient
  logic [MAG_W-1:0]          win [3][3];
  logic [2*GRAD_W-1:0]       centre_grad;
  logic signed [GRAD_W-1:0]  ux2, uy2;
  pix_tag_t                  tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2          <= 1'b0;
      centre_grad <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (s2_free) begin
      v2 <= v1;
      if (v1) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
        end
        win[0][2]   <= top_q;
        win[1][2]   <= mid_q;
        win[2][2]   <= mag1;
        centre_grad <= grad_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv12) begin
      ux2  <= centre_grad[GRAD_W-1:0];
      uy2  <= centre_grad[2*GRAD_W-1:GRAD_W];
      tag2 <= tag1;
    end
  end

  // quadrant selection and products
  logic [GRAD_W-1:0]          abs_x, abs_y;
  logic                       steep, pos;
  logic signed [GRAD_W-1:0]   coef_a, coef_b;
  logic signed [GRAD_W+1:0]   coef_a_e, coef_b_e, coef_d;
  logic [MAG_W-1:0]           diag1, diag2, side1, side2;
  logic signed [PROD_W-1:0]   p_ag_next, p_b1_next, p_d1_next, p_b2_next, p_d2_next;

  always_comb begin
    abs_x = ux2[GRAD_W-1] ? GRAD_W'(-ux2) : GRAD_W'(ux2);
    abs_y = uy2[GRAD_W-1] ? GRAD_W'(-uy2) : GRAD_W'(uy2);
    steep = abs_x < abs_y;
    pos   = (ux2 != '0) && (uy2 != '0) && (ux2[GRAD_W-1] == uy2[GRAD_W-1]);
    coef_a   = steep ? uy2 : ux2;
    coef_b   = steep ? ux2 : uy2;
    coef_a_e = (GRAD_W+2)'(coef_a);
    coef_b_e = (GRAD_W+2)'(coef_b);
    coef_d   = pos ? (coef_a_e - coef_b_e) : -(coef_a_e + coef_b_e);
    diag1 = pos ? win[2][2] : win[0][2];
    diag2 = pos ? win[0][0] : win[2][0];
    side1 = steep ? (pos ? win[2][1] : win[0][1]) : win[1][2];
    side2 = steep ? (pos ? win[0][1] : win[2][1]) : win[1][0];
    p_ag_next = PROD_W'(coef_a) * PROD_W'($signed({1'b0, win[1][1]}));
    p_b1_next = PROD_W'(coef_b) * PROD_W'($signed({1'b0, diag1}));
    p_d1_next = PROD_W'(coef_d) * PROD_W'($signed({1'b0, side1}));
    p_b2_next = PROD_W'(coef_b) * PROD_W'($signed({1'b0, diag2}));
    p_d2_next = PROD_W'(coef_d) * PROD_W'($signed({1'b0, side2}));
  end

  // stage 3: registered products
  logic signed [PROD_W-1:0] p_ag, p_b1, p_d1, p_b2, p_d2;
  logic                     strict1, strict2;
  logic [MAG_W-1:0]         centre3;
  pix_tag_t                 tag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_free) begin
      // drop border items here
      v3 <= v2 && tag2.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      p_ag    <= p_ag_next;
      p_b1    <= p_b1_next;
      p_d1    <= p_d1_next;
      p_b2    <= p_b2_next;
      p_d2    <= p_d2_next;
      strict1 <= !pos && steep;
      strict2 <= !pos && !steep;
      centre3 <= win[1][1];
      tag3    <= tag2;
    end
  end

  // compare and output register
  logic [SUM_W-1:0] g0, m1, m2;
  logic             sup1, sup2, keep;

  always_comb begin
    g0   = abs_of(SUM_W'(p_ag));
    m1   = abs_of(SUM_W'(p_b1) + SUM_W'(p_d1));
    m2   = abs_of(SUM_W'(p_b2) + SUM_W'(p_d2));
    sup1 = strict1 ? (g0 < m1) : (g0 <= m1);
    sup2 = strict2 ? (g0 < m2) : (g0 <= m2);
    keep = !(sup1 || sup2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      edge_value    <= keep ? centre3 : '0;
      kept          <= keep;
      pixel_row     <= tag3.row;
      pixel_col     <= tag3.col;
      last_of_frame <= tag3.last;
    end
  end

endmodule

/* sv/cnms_checker.sv */
module cnms_checker import cnms_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [MAG_W-1:0]         edge_value,
  input logic                     kept,
  input logic [POS_W-1:0]         pixel_row,
  input logic [POS_W-1:0]         pixel_col,
  input logic                     last_of_frame
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_value) && $stable(kept) &&
      $stable(pixel_row) && $stable(pixel_col) && $stable(last_of_frame))
    else $error("stalled result changed");

  // suppressed pixel carries zero, top and left border never reported
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kept || edge_value == '0) && pixel_row != '0 && pixel_col != '0)
    else $error("malformed result");

  // a new frame needs two rows before its first result
  a_frame_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_frame |=> !out_valid)
    else $error("result right after end of frame");

endmodule

bind canny_nonmax_suppression_unit cnms_checker u_cnms_checker (.*);
